// File: sv/imu_serial_frame_decoder_macros.svh
// Assertion macros shared by the serial frame decoder.
// No dependencies; included by the top level only.
`ifndef IMU_SERIAL_FRAME_DECODER_MACROS_SVH
`define IMU_SERIAL_FRAME_DECODER_MACROS_SVH

// Condition must never hold outside reset.
`define ISFD_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("isfd check failed: never");

// Antecedent in one cycle implies consequent in the next.
`define ISFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isfd check failed: next cycle");

`endif

// File: sv/isfd_pkg.sv
// Types and constants for the serial frame decoder.
// No dependencies; imported by every decoder module.
`default_nettype none

package isfd_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned RAW_W         = 16;
    localparam int unsigned AXIS_W        = 23;
    localparam int unsigned PROD_W        = 23;
    localparam int unsigned TEMP_W        = 16;
    localparam int unsigned SCALE_W       = 8;
    localparam int unsigned POS_W         = 4;
    localparam int unsigned PAYLOAD_BYTES = 8;
    localparam int unsigned PAYLOAD_IDX_W = 3;
    localparam int unsigned FRAME_BYTES   = 11;
    localparam int unsigned TDATA_W       = 88;
    localparam int unsigned TDATA_PAD_W   = TDATA_W - 3 * AXIS_W - TEMP_W;

    // Byte codes
    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] TYPE_RATE   = 8'h52;
    localparam logic [BYTE_W-1:0] TYPE_ANGLE  = 8'h53;

    // Fixed-point scale factors
    localparam logic signed [SCALE_W-1:0] RATE_SCALE  = 8'sd125;
    localparam logic signed [SCALE_W-1:0] ANGLE_SCALE = 8'sd45;

    // Positions within a frame
    localparam logic [POS_W-1:0] POS_IDLE       = 4'd0;
    localparam logic [POS_W-1:0] POS_TYPE       = 4'd1;
    localparam logic [POS_W-1:0] POS_DATA_FIRST = 4'd2;
    localparam logic [POS_W-1:0] POS_CHECKSUM   = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_END        = POS_W'(FRAME_BYTES);

    typedef enum logic {
        KIND_RATE  = 1'b0,
        KIND_ANGLE = 1'b1
    } frame_kind_t;

    // One completed frame waiting to be scaled
    typedef struct packed {
        frame_kind_t              kind;
        logic signed [RAW_W-1:0]  x_raw;
        logic signed [RAW_W-1:0]  y_raw;
        logic signed [RAW_W-1:0]  z_raw;
        logic signed [RAW_W-1:0]  temp_raw;
    } frame_rec_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// File: sv/isfd_front.sv
// Front end: accepts serial bytes and assembles frames.
// Depends on isfd_pkg; pushes completed rate and angle frames into isfd_queue.
`default_nettype none

module isfd_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [isfd_pkg::BYTE_W-1:0] s_byte,
    input  wire isfd_pkg::q_status_t        q_status,
    output logic                            push,
    output isfd_pkg::frame_rec_t            push_rec
);
    import isfd_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] type_reg;
    logic [BYTE_W-1:0] payload_reg [PAYLOAD_BYTES];
    logic              at_checksum;
    logic              known_type;
    logic              accept;
    logic [PAYLOAD_IDX_W-1:0] data_off;

    // Frame classification
    assign at_checksum = (pos_reg == POS_CHECKSUM);
    assign known_type  = (type_reg == TYPE_RATE) || (type_reg == TYPE_ANGLE);

    // Stall only the checksum byte of a reported frame while the queue is full
    assign s_ready = !(at_checksum && known_type && q_status.full);
    assign accept  = s_valid && s_ready;
    assign push    = accept && at_checksum && known_type;
    assign data_off = PAYLOAD_IDX_W'(pos_reg - POS_DATA_FIRST);

    // Next byte position
    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (pos_reg == POS_IDLE || pos_reg >= POS_END) begin
                pos_next = (s_byte == HEADER_BYTE) ? POS_TYPE : POS_IDLE;
            end else if (pos_reg == POS_TYPE) begin
                pos_next = POS_DATA_FIRST;
            end else if (pos_reg < POS_CHECKSUM) begin
                pos_next = pos_reg + POS_W'(1);
            end else begin
                pos_next = POS_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_IDLE;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // Type and payload capture
    always_ff @(posedge aclk) begin
        if (accept && pos_reg == POS_TYPE) begin
            type_reg <= s_byte;
        end
        if (accept && pos_reg >= POS_DATA_FIRST && pos_reg < POS_CHECKSUM) begin
            payload_reg[data_off] <= s_byte;
        end
    end

    // Little-endian words of the finished frame
    always_comb begin
        push_rec.kind     = (type_reg == TYPE_ANGLE) ? KIND_ANGLE : KIND_RATE;
        push_rec.x_raw    = {payload_reg[1], payload_reg[0]};
        push_rec.y_raw    = {payload_reg[3], payload_reg[2]};
        push_rec.z_raw    = {payload_reg[5], payload_reg[4]};
        push_rec.temp_raw = {payload_reg[7], payload_reg[6]};
    end

endmodule

`default_nettype wire

// File: sv/isfd_queue.sv
// Short frame queue between the assembler and the scaler.
// Depends on isfd_pkg for the frame record and status types.
`default_nettype none

module isfd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire isfd_pkg::frame_rec_t push_rec,
    input  wire logic                 pop,
    output isfd_pkg::frame_rec_t      head_rec,
    output isfd_pkg::q_status_t       status
);
    import isfd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    frame_rec_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign head_rec     = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

// File: sv/isfd_back.sv
// Back end: scales queued frames and holds the result for the output.
// Depends on isfd_pkg; pops records from isfd_queue.
`default_nettype none

module isfd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire isfd_pkg::q_status_t           q_status,
    input  wire isfd_pkg::frame_rec_t          head_rec,
    output logic                               pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output isfd_pkg::frame_kind_t              m_kind,
    output logic signed [isfd_pkg::AXIS_W-1:0] m_x,
    output logic signed [isfd_pkg::AXIS_W-1:0] m_y,
    output logic signed [isfd_pkg::AXIS_W-1:0] m_z,
    output logic signed [isfd_pkg::TEMP_W-1:0] m_temp
);
    import isfd_pkg::*;

    logic                        out_valid_reg;
    frame_kind_t                 kind_reg;
    logic signed [AXIS_W-1:0]    x_reg, y_reg, z_reg;
    logic signed [TEMP_W-1:0]    temp_reg;
    logic signed [SCALE_W-1:0]   scale;
    logic signed [PROD_W-1:0]    x_prod, y_prod, z_prod;

    // Load a new result when the output slot is free or being taken
    assign pop = !q_status.empty && (!out_valid_reg || m_ready);

    // Constant scaling, exact in fixed point
    assign scale  = (head_rec.kind == KIND_ANGLE) ? ANGLE_SCALE : RATE_SCALE;
    assign x_prod = head_rec.x_raw * scale;
    assign y_prod = head_rec.y_raw * scale;
    assign z_prod = head_rec.z_raw * scale;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg <= head_rec.kind;
            x_reg    <= x_prod[AXIS_W-1:0];
            y_reg    <= y_prod[AXIS_W-1:0];
            z_reg    <= z_prod[AXIS_W-1:0];
            temp_reg <= head_rec.temp_raw;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_kind  = kind_reg;
    assign m_x     = x_reg;
    assign m_y     = y_reg;
    assign m_z     = z_reg;
    assign m_temp  = temp_reg;

endmodule

`default_nettype wire

// File: sv/imu_serial_frame_decoder.sv
// A finished frame passes through the frame queue and then the output register.
// Throughput: one byte per cycle but for the stall below; the scaler drains one frame
// per cycle while its output is free or taken. The input stalls only on the checksum
// byte of a rate or angle frame while the frame queue (QUEUE_DEPTH entries) is full.
// Reset: synchronous, active low; clears byte position, queue and output
// valid. No clearing pass.
`default_nettype none

module imu_serial_frame_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Byte input
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
    // Result output
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [22:0] x_value, [45:23] y_value, [68:46] z_value, [84:69] temperature, pad
    output logic [isfd_pkg::TDATA_W-1:0]         m_axis_tdata,
    output logic [0:0]                           m_axis_tuser   // [0] frame_kind
);
    import isfd_pkg::*;

`include "imu_serial_frame_decoder_macros.svh"

    q_status_t               q_status;
    frame_rec_t              push_rec;
    frame_rec_t              head_rec;
    logic                    push;
    logic                    pop;
    frame_kind_t             res_kind;
    logic signed [AXIS_W-1:0] res_x, res_y, res_z;
    logic signed [TEMP_W-1:0] res_temp;

    // Frame assembly
    isfd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_byte   (s_axis_tdata),
        .q_status (q_status),
        .push     (push),
        .push_rec (push_rec)
    );

    // Decoupling queue
    isfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .status   (q_status)
    );

    // Scaling and output register
    isfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .head_rec (head_rec),
        .pop      (pop),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_kind   (res_kind),
        .m_x      (res_x),
        .m_y      (res_y),
        .m_z      (res_z),
        .m_temp   (res_temp)
    );

    assign m_axis_tdata = {{TDATA_PAD_W{1'b0}}, res_temp, res_z, res_y, res_x};
    assign m_axis_tuser = res_kind;

    // Checks
    `ISFD_ASSERT_NEVER(a_no_push_when_full, aclk, aresetn, push && q_status.full)
    `ISFD_ASSERT_NEXT(a_push_fills_queue, aclk, aresetn, push, !q_status.empty)
    `ISFD_ASSERT_NEXT(a_pop_gives_result, aclk, aresetn, pop, m_axis_tvalid)

endmodule

`default_nettype wire
